// File: design/kmp_pkg.sv
// shared types for the kmp substring matcher
package kmp_pkg;

   typedef struct packed {
      logic       action;
      logic [7:0] symbol;
      logic       final_byte;
   } req_payload_type;

   typedef struct packed {
      logic found;
      logic pattern_overflow;
   } rsp_payload_type;

   // action codes
   localparam logic ACTION_PATTERN = 1'b0;
   localparam logic ACTION_TEXT    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic walk;
      logic finish;
      logic emit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_walk;
      logic emit_now;
      logic walk_more;
      logic last_text;
      logic slot_free;
   } dp_status_type;

endpackage

// File: design/kmp_substring_matcher.sv
// top level of the streaming kmp substring matcher
//
// Streaming substring matcher. Pattern bytes (action 0) are stored one per
// transaction and the failure table entry for each is built as it arrives;
// text bytes (action 1) are matched with failure-link fallback, and the text
// byte marked final_byte returns one result transaction with found and
// pattern_overflow. A pattern byte arriving after a finished pattern starts a
// new pattern and clears scan progress; bytes past MAX_PATTERN are dropped
// and flagged. Timing: the block works on one byte at a time. Each byte
// is accepted in the idle state; a text byte or non-first pattern byte
// then tries positions of the fallback chain in the step state, one link
// per cycle, since the failure table has one read port. The first pattern
// byte, a dropped byte, or a text byte after a hit or with an empty
// pattern skips the step state. A final text byte then loads the result
// register, waiting while the previous result is still unread. Amortized
// over a text the fallback count stays below one per byte. No clearing
// pass after reset: the stores are only read below the loaded length.
module kmp_substring_matcher #(
   parameter int MAX_PATTERN = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   // input transactions
   input  logic                     req_valid,
   output logic                     req_ready,
   input  kmp_pkg::req_payload_type req_payload,
   // result transactions
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output kmp_pkg::rsp_payload_type rsp_payload
);

   // command and status between the sequencer and the datapath
   kmp_pkg::ctrl_cmd_type  cmd;
   kmp_pkg::dp_status_type status;

   // sequencer: accept, fallback walk, result hand-off
   kmp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, match state and the output register
   kmp_datapath #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: design/kmp_controller.sv
// sequencing state machine for the kmp substring matcher
module kmp_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  kmp_pkg::dp_status_type status,
   output kmp_pkg::ctrl_cmd_type  cmd
);

   kmp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kmp_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.need_walk) begin
                  state_in = kmp_pkg::ST_STEP;
               end else if (status.emit_now) begin
                  state_in = kmp_pkg::ST_OUT;
               end
            end
         end
         kmp_pkg::ST_STEP: begin
            if (!status.walk_more) begin
               state_in = status.last_text ? kmp_pkg::ST_OUT : kmp_pkg::ST_IDLE;
            end
         end
         kmp_pkg::ST_OUT: begin
            if (status.slot_free) begin
               state_in = kmp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kmp_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         kmp_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         kmp_pkg::ST_STEP: begin
            cmd.walk   = status.walk_more;
            cmd.finish = !status.walk_more;
         end
         kmp_pkg::ST_OUT: begin
            cmd.emit = status.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: design/kmp_datapath.sv
// pattern store, failure table, match state and result register
module kmp_datapath #(
   parameter int MAX_PATTERN = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  kmp_pkg::req_payload_type req_payload,
   input  kmp_pkg::ctrl_cmd_type    cmd,
   output kmp_pkg::dp_status_type   status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output kmp_pkg::rsp_payload_type rsp_payload
);

   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LW = $clog2(MAX_PATTERN + 1);
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);

   // memories
   logic [7:0]    pattern_store_ff [MAX_PATTERN];
   logic [IW-1:0] failure_table_ff [MAX_PATTERN];
   logic [7:0]    store_rdata_ff;
   logic [IW-1:0] fail_rdata_ff;

   // control state
   logic [LW-1:0] length_ff, length_in;
   logic [IW-1:0] prefix_ff, prefix_in;
   logic [IW-1:0] match_ff, match_in;
   logic          found_ff, found_in;
   logic          done_ff, done_in;
   logic          overflow_ff, overflow_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // item registers
   logic [IW-1:0]            k_ff, k_in;
   logic [7:0]               sym_ff, sym_in;
   logic                     action_ff, action_in;
   logic                     last_ff, last_in;
   kmp_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [LW-1:0] eff_len;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [IW-1:0] fail_wdata;
   logic [IW-1:0] rd_addr;
   logic          k_lt_len;
   logic          sym_eq;
   logic [LW-1:0] k_fin;
   logic          is_pattern;

   assign is_pattern = (req_payload.action == kmp_pkg::ACTION_PATTERN);
   assign eff_len    = done_ff ? '0 : length_ff;
   assign wr_en      = cmd.accept && is_pattern && (eff_len != MAX_LEN);
   assign wr_addr    = eff_len[IW-1:0];
   assign fail_wdata = (eff_len == '0) ? '0 : prefix_ff;
   assign rd_addr    = cmd.walk ? fail_rdata_ff : (is_pattern ? prefix_ff : match_ff);

   assign k_lt_len = ({{(LW-IW){1'b0}}, k_ff} < length_ff);
   assign sym_eq   = (store_rdata_ff == sym_ff);
   assign k_fin    = {{(LW-IW){1'b0}}, k_ff} + LW'(k_lt_len && sym_eq);

   always_comb begin
      status.need_walk = is_pattern ? ((eff_len != '0) && (eff_len != MAX_LEN))
                                    : (!found_ff && (length_ff != '0));
      status.emit_now  = !is_pattern && req_payload.final_byte && !status.need_walk;
      status.walk_more = (k_ff != '0) && k_lt_len && !sym_eq;
      status.last_text = (action_ff == kmp_pkg::ACTION_TEXT) && last_ff;
      status.slot_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pattern_store_ff[wr_addr] <= req_payload.symbol;
         failure_table_ff[wr_addr] <= fail_wdata;
      end
      store_rdata_ff <= pattern_store_ff[rd_addr];
      fail_rdata_ff  <= failure_table_ff[rd_addr];
   end

   always_comb begin
      length_in    = length_ff;
      prefix_in    = prefix_ff;
      match_in     = match_ff;
      found_in     = found_ff;
      done_in      = done_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      k_in         = k_ff;
      sym_in       = sym_ff;
      action_in    = action_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;

      if (cmd.accept) begin
         sym_in    = req_payload.symbol;
         action_in = req_payload.action;
         last_in   = req_payload.final_byte;
         if (is_pattern) begin
            // a byte after a finished pattern starts a new one
            if (done_ff) begin
               length_in   = '0;
               prefix_in   = '0;
               overflow_in = 1'b0;
               match_in    = '0;
               found_in    = 1'b0;
               done_in     = 1'b0;
            end
            if (eff_len == MAX_LEN) begin
               overflow_in = 1'b1;
               done_in     = req_payload.final_byte;
            end else if (eff_len == '0) begin
               length_in = LW'(1);
               prefix_in = '0;
               done_in   = req_payload.final_byte;
            end else begin
               k_in = prefix_ff;
            end
         end else begin
            if (!found_ff) begin
               if (length_ff == '0) begin
                  found_in = 1'b1;
               end else begin
                  k_in = match_ff;
               end
            end
         end
      end

      if (cmd.walk) begin
         k_in = fail_rdata_ff;
      end

      if (cmd.finish) begin
         if (action_ff == kmp_pkg::ACTION_PATTERN) begin
            prefix_in = k_fin[IW-1:0];
            length_in = length_ff + LW'(1);
            done_in   = last_ff;
         end else if (k_fin >= length_ff) begin
            found_in = 1'b1;
            match_in = '0;
         end else begin
            match_in = k_fin[IW-1:0];
         end
      end

      if (cmd.emit) begin
         rsp_valid_in            = 1'b1;
         rsp_in.found            = found_ff;
         rsp_in.pattern_overflow = overflow_ff;
         match_in                = '0;
         found_in                = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         prefix_ff    <= '0;
         match_ff     <= '0;
         found_ff     <= 1'b0;
         done_ff      <= 1'b1;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         prefix_ff    <= prefix_in;
         match_ff     <= match_in;
         found_ff     <= found_in;
         done_ff      <= done_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      sym_ff    <= sym_in;
      action_ff <= action_in;
      last_ff   <= last_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // match progress stays inside the stored pattern
   a_match_in_range: assert property (@(posedge clock) disable iff (reset)
      ({{(LW-IW){1'b0}}, match_ff} < length_ff) || (match_ff == '0))
      else $error("match position beyond pattern length");

   // border is always a proper prefix
   a_prefix_in_range: assert property (@(posedge clock) disable iff (reset)
      ({{(LW-IW){1'b0}}, prefix_ff} < length_ff) || (prefix_ff == '0))
      else $error("prefix border beyond pattern length");

   a_length_cap: assert property (@(posedge clock) disable iff (reset)
      length_ff <= MAX_LEN)
      else $error("pattern length above capacity");

   // a failure link is followed only from a nonzero position
   a_walk_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (k_ff != '0))
      else $error("failure link followed from position zero");

   // a result is never loaded over one still waiting
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

endmodule

// File: verif/kmp_substring_matcher_tb.sv
// self-checking testbench for the streaming kmp substring matcher
`timescale 1ns / 100ps

module kmp_substring_matcher_tb;

   localparam int PATTERN_CAP  = 64;
   localparam int RANDOM_ITEMS = 430;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 20;

   typedef logic [7:0] byte_string_type [$];

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   kmp_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   kmp_pkg::rsp_payload_type rsp_payload;

   // verdicts the matcher still owes us, oldest first
   kmp_pkg::rsp_payload_type expected_verdicts [$];

   int  error_count  = 0;
   int  items_sent   = 0;
   int  cycle_count  = 0;
   // while set, neither side inserts random idle cycles
   bit  quiet_mode   = 1'b0;
   // long receiver hold-off: the test bumps holds_asked, the receiver serves it
   int  holds_asked  = 0;
   int  holds_served = 0;
   int  hold_left    = 0;

   // shadow copy of the matcher state
   logic [7:0] pat_bytes   [PATTERN_CAP];
   logic [6:0] border_link [PATTERN_CAP];
   logic [6:0] pat_len        = '0;
   logic [6:0] border_len     = '0;
   logic [6:0] scan_pos       = '0;
   logic       hit_seen       = 1'b0;
   logic       pattern_closed = 1'b1;
   logic       truncated      = 1'b0;

   kmp_substring_matcher #(
      .MAX_PATTERN(PATTERN_CAP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // walk failure links from k until c extends the partial match
   function automatic logic [6:0] advance_match(logic [6:0] k, logic [7:0] c);
      while (k > 0 && k < pat_len && pat_bytes[k] != c)
         k = border_link[k];
      if (k < pat_len && pat_bytes[k] == c)
         k++;
      return k;
   endfunction

   // append one pattern byte and build its failure link
   function automatic void load_symbol(logic [7:0] c);
      logic [6:0] k;
      if (pat_len >= PATTERN_CAP) begin
         // past capacity: byte is dropped, only the flag remembers it
         truncated = 1'b1;
         return;
      end
      pat_bytes[pat_len] = c;
      if (pat_len == 0) begin
         border_link[0] = '0;
         border_len     = '0;
      end else begin
         border_link[pat_len] = border_len;
         k = border_len;
         while (k > 0 && pat_bytes[k] != c)
            k = border_link[k];
         if (pat_bytes[k] == c)
            k++;
         border_len = k;
      end
      pat_len++;
   endfunction

   function automatic void scan_symbol(logic [7:0] c);
      // once the pattern was seen the rest of the text is ignored
      if (hit_seen)
         return;
      // empty pattern occurs in any non-empty text
      if (pat_len == 0) begin
         hit_seen = 1'b1;
         return;
      end
      scan_pos = advance_match(scan_pos, c);
      if (scan_pos >= pat_len) begin
         hit_seen = 1'b1;
         scan_pos = '0;
      end
   endfunction

   // returns 1 when the transaction produces a verdict
   function automatic bit predict_verdict(input kmp_pkg::req_payload_type item,
                                          output kmp_pkg::rsp_payload_type verdict);
      verdict = '0;
      if (item.action == kmp_pkg::ACTION_PATTERN) begin
         // first byte after a finished pattern starts over and drops scan progress
         if (pattern_closed) begin
            pat_len        = '0;
            border_len     = '0;
            truncated      = 1'b0;
            scan_pos       = '0;
            hit_seen       = 1'b0;
            pattern_closed = 1'b0;
         end
         load_symbol(item.symbol);
         if (item.final_byte)
            pattern_closed = 1'b1;
         return 1'b0;
      end
      scan_symbol(item.symbol);
      if (!item.final_byte)
         return 1'b0;
      verdict.found            = hit_seen;
      verdict.pattern_overflow = truncated;
      scan_pos = '0;
      hit_seen = 1'b0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // driving
   // ---------------------------------------------------------------------

   // offer one transaction; valid stays high afterwards unless a gap follows
   task automatic send_item(input logic act, input logic [7:0] sym, input logic last);
      kmp_pkg::req_payload_type item;
      kmp_pkg::rsp_payload_type verdict;
      item.action     = act;
      item.symbol     = sym;
      item.final_byte = last;
      if (!quiet_mode && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      // accepted at this edge
      if (predict_verdict(item, verdict))
         expected_verdicts.push_back(verdict);
      items_sent++;
   endtask

   // whole pattern or text, final_byte on the last byte
   task automatic send_string(input logic act, input byte_string_type s);
      for (int i = 0; i < s.size(); i++)
         send_item(act, s[i], i == s.size() - 1);
   endtask

   function automatic byte_string_type random_string(int len, byte_string_type alphabet);
      byte_string_type s;
      for (int i = 0; i < len; i++)
         s.push_back(alphabet[$urandom_range(0, alphabet.size() - 1)]);
      return s;
   endfunction

   function automatic byte_string_type random_alphabet(int size);
      byte_string_type s;
      for (int i = 0; i < size; i++)
         s.push_back(8'($urandom_range(0, 255)));
      return s;
   endfunction

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // receiver and checking
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         // start a long hold-off so results pile up inside the block
         holds_served <= holds_asked;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= quiet_mode || ($urandom_range(0, 99) >= 23);
      end
   end

   always @(posedge clock) begin
      kmp_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected result transaction: found %0b pattern_overflow %0b",
                   rsp_payload.found, rsp_payload.pattern_overflow);
            error_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_payload.found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_payload.found);
               error_count++;
            end
            if (rsp_payload.pattern_overflow !== want.pattern_overflow) begin
               $error("pattern_overflow: expected %0b, got %0b",
                      want.pattern_overflow, rsp_payload.pattern_overflow);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("kmp_substring_matcher: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // nothing loaded since reset: every text reports a hit
   task automatic test_empty_pattern();
      send_item(kmp_pkg::ACTION_TEXT, 8'h5A, 1'b1);
      send_item(kmp_pkg::ACTION_TEXT, 8'h00, 1'b0);
      send_item(kmp_pkg::ACTION_TEXT, 8'hFF, 1'b1);
   endtask

   task automatic test_directed();
      // pattern 00 ff, then a text that needs a fallback to find it
      send_string(kmp_pkg::ACTION_PATTERN, '{8'h00, 8'hFF});
      send_string(kmp_pkg::ACTION_TEXT, '{8'h00, 8'h00, 8'hFF});
      // text shorter than the pattern
      send_string(kmp_pkg::ACTION_TEXT, '{8'hFF});
      // text scanned while the pattern is still being loaded
      send_item(kmp_pkg::ACTION_PATTERN, 8'h41, 1'b0);
      send_string(kmp_pkg::ACTION_TEXT, '{8'h41});
      // later byte extends the same pattern to 41 42
      send_item(kmp_pkg::ACTION_PATTERN, 8'h42, 1'b1);
      send_string(kmp_pkg::ACTION_TEXT, '{8'h41, 8'h41, 8'h42});
      // a new pattern in the middle of a text wipes the partial scan
      send_item(kmp_pkg::ACTION_TEXT, 8'h41, 1'b0);
      send_item(kmp_pkg::ACTION_PATTERN, 8'h43, 1'b1);
      send_string(kmp_pkg::ACTION_TEXT, '{8'h43});
      drain_results();
   endtask

   // patterns past capacity, and one exactly at capacity
   task automatic test_pattern_overflow();
      byte_string_type alphabet;
      byte_string_type pat;
      byte_string_type text;
      for (int round = 0; round < 3; round++) begin
         alphabet = random_alphabet(2);
         pat = random_string(round == 2 ? PATTERN_CAP : $urandom_range(65, 70), alphabet);
         send_string(kmp_pkg::ACTION_PATTERN, pat);
         // text holding the whole pattern, so the kept prefix is found too
         text = random_string($urandom_range(0, 4), alphabet);
         foreach (pat[i]) text.push_back(pat[i]);
         send_string(kmp_pkg::ACTION_TEXT, text);
         send_string(kmp_pkg::ACTION_TEXT, random_string($urandom_range(1, 6), alphabet));
      end
      drain_results();
   endtask

   // mostly well-formed pattern/text sequences over small alphabets, some noise
   task automatic test_random_sequences();
      byte_string_type alphabet;
      byte_string_type pat;
      byte_string_type text;
      int start;
      int roll;
      int text_len;
      int pos;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         // one long stretch with no idling on either side
         quiet_mode <= (items_sent - start >= 100) && (items_sent - start < 250);
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            // noise: any action, any byte, broken sequences
            repeat ($urandom_range(1, 6))
               send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         $urandom_range(0, 99) < 30);
         end else begin
            alphabet = random_alphabet($urandom_range(1, 4));
            roll = $urandom_range(0, 99);
            if (roll < 90)
               pat = random_string($urandom_range(1, 8), alphabet);
            else if (roll < 96)
               pat = random_string($urandom_range(9, PATTERN_CAP), alphabet);
            else
               pat = random_string($urandom_range(PATTERN_CAP + 1, PATTERN_CAP + 6),
                                   alphabet);
            send_string(kmp_pkg::ACTION_PATTERN, pat);
            repeat ($urandom_range(1, 4)) begin
               text_len = $urandom_range(1, pat.size() + 8);
               text = random_string(text_len, alphabet);
               // plant the pattern in about half the texts
               if ($urandom_range(0, 1) == 1 && pat.size() <= text_len) begin
                  pos = $urandom_range(0, text_len - pat.size());
                  foreach (pat[i]) text[pos + i] = pat[i];
               end
               send_string(kmp_pkg::ACTION_TEXT, text);
            end
         end
      end
      quiet_mode <= 1'b0;
      drain_results();
   endtask

   // receiver holds off while single-byte texts keep coming, so the input stalls
   task automatic test_output_stall();
      send_string(kmp_pkg::ACTION_PATTERN, '{8'h33});
      quiet_mode  <= 1'b1;
      holds_asked <= holds_asked + 1;
      repeat (40)
         send_item(kmp_pkg::ACTION_TEXT, $urandom_range(0, 1) == 1 ? 8'h33 : 8'hCC, 1'b1);
      quiet_mode <= 1'b0;
      drain_results();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_pattern();
      test_directed();
      test_pattern_overflow();
      test_output_stall();
      test_random_sequences();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_verdicts.size() == 0)
         $display("kmp_substring_matcher: match");
      else
         $display("kmp_substring_matcher: mismatch");
      $finish;
   end

endmodule
